// File: hw/rtl/qpn_pkg.sv
// Shared constants and types for the normalized quaternion product block.
`timescale 1ns / 1ps

package qpn_pkg;

   // Width of a prescaled component magnitude; the prescale keeps |v| below 2^31.
   localparam int MAG_WIDTH = 31;
   // Width of one squared magnitude and of the sum of four of them.
   localparam int SQ_WIDTH  = 2 * MAG_WIDTH;
   localparam int TOT_WIDTH = SQ_WIDTH + 2;

   // Hamilton product: result component c, term t is a[t] * b[TERM_B[c][t]],
   // subtracted when TERM_NEG[c][t] is set. Order is w, x, y, z.
   localparam logic [1:0] TERM_B [4][4] = '{
      '{2'd0, 2'd1, 2'd2, 2'd3},
      '{2'd1, 2'd0, 2'd3, 2'd2},
      '{2'd2, 2'd3, 2'd0, 2'd1},
      '{2'd3, 2'd2, 2'd1, 2'd0}
   };
   localparam logic TERM_NEG [4][4] = '{
      '{1'b0, 1'b1, 1'b1, 1'b1},
      '{1'b0, 1'b0, 1'b0, 1'b1},
      '{1'b0, 1'b1, 1'b0, 1'b0},
      '{1'b0, 1'b0, 1'b1, 1'b0}
   };

   // Control that travels with each item through the root search stages.
   typedef struct packed {
      logic       valid;
      logic       zero;
      logic [3:0] neg;
   } stage_ctl_type;

endpackage

// File: hw/rtl/qpn_if.sv
// Request and response channel interfaces of the normalized quaternion product block.
`timescale 1ns / 1ps

interface qpn_req_if #(parameter int COMPONENT_WIDTH = 16);
   logic                              valid;
   logic                              ready;
   logic signed [COMPONENT_WIDTH-1:0] a_w;
   logic signed [COMPONENT_WIDTH-1:0] a_x;
   logic signed [COMPONENT_WIDTH-1:0] a_y;
   logic signed [COMPONENT_WIDTH-1:0] a_z;
   logic signed [COMPONENT_WIDTH-1:0] b_w;
   logic signed [COMPONENT_WIDTH-1:0] b_x;
   logic signed [COMPONENT_WIDTH-1:0] b_y;
   logic signed [COMPONENT_WIDTH-1:0] b_z;

   modport source (output valid, a_w, a_x, a_y, a_z, b_w, b_x, b_y, b_z, input ready);
   modport sink   (input valid, a_w, a_x, a_y, a_z, b_w, b_x, b_y, b_z, output ready);
endinterface

interface qpn_rsp_if #(parameter int COMPONENT_WIDTH = 16);
   logic                              valid;
   logic                              ready;
   logic signed [COMPONENT_WIDTH-1:0] out_w;
   logic signed [COMPONENT_WIDTH-1:0] out_x;
   logic signed [COMPONENT_WIDTH-1:0] out_y;
   logic signed [COMPONENT_WIDTH-1:0] out_z;
   logic                              degenerate;

   modport source (output valid, out_w, out_x, out_y, out_z, degenerate, input ready);
   modport sink   (input valid, out_w, out_x, out_y, out_z, degenerate, output ready);
endinterface

// File: hw/rtl/quaternion_product_normalized.sv
// Top level of the normalized Hamilton quaternion product pipeline.
//
// Usage: an item on req_chan carries two quaternions a and b in signed Q2.F,
// F = COMPONENT_WIDTH - 2. The block forms the exact product a*b and returns
// it on rsp_chan scaled to unit length, each component rounded to nearest
// with ties away from zero. A product that is exactly zero comes out as zero
// with degenerate raised.
// A transfer happens on either channel when valid and ready are both high.
// Throughput is one item per cycle while the receiver does not stall the
// pipeline; the depth is set by the rounding search, which spends one
// register stage per result bit.
// When the receiver holds rsp_chan.ready low with a response waiting, the
// whole pipeline freezes and req_chan.ready drops in the same cycle; nothing
// is lost or repeated. Reset, synchronous and active high, empties every
// stage; there is no other state.
`timescale 1ns / 1ps

module quaternion_product_normalized #(
   parameter int COMPONENT_WIDTH = 16
) (
   input  logic      clock,
   input  logic      reset,
   qpn_req_if.sink   req_chan,
   qpn_rsp_if.source rsp_chan
);

   localparam int W    = COMPONENT_WIDTH;
   localparam int FRAC = W - 2;
   localparam int PRW  = 2 * W;               // one term of the product
   localparam int PW   = 2 * W + 2;           // sum of four terms
   localparam int EW   = PW + 32;             // room for the prescale range check
   localparam int NS   = (PW > 32) ? PW - 31 : 1;
   localparam int SW   = (NS > 1) ? $clog2(NS) : 1;
   localparam int MW   = qpn_pkg::MAG_WIDTH;
   localparam int SQW  = qpn_pkg::SQ_WIDTH;
   localparam int TW   = qpn_pkg::TOT_WIDTH;
   localparam int RW   = 2 * FRAC + 70;
   localparam int QW   = FRAC + 1;

   // The pipeline advances whenever the output register is empty or drained.
   logic en;
   logic signed [W-1:0] a_in [4];
   logic signed [W-1:0] b_in [4];

   assign en = !rsp_chan.valid || rsp_chan.ready;
   assign req_chan.ready = en;

   assign a_in[0] = req_chan.a_w;
   assign a_in[1] = req_chan.a_x;
   assign a_in[2] = req_chan.a_y;
   assign a_in[3] = req_chan.a_z;
   assign b_in[0] = req_chan.b_w;
   assign b_in[1] = req_chan.b_x;
   assign b_in[2] = req_chan.b_y;
   assign b_in[3] = req_chan.b_z;

   // ---------------------------------------------------------------------
   // Stage 1: the sixteen signed partial products, sign of the term applied.
   // ---------------------------------------------------------------------
   logic                 valid1_ff;
   logic signed [PRW-1:0] prod1_ff [4][4];
   logic signed [PRW-1:0] prod1_in [4][4];

   always_comb begin
      logic signed [PRW-1:0] p;
      for (int c = 0; c < 4; c++) begin
         for (int t = 0; t < 4; t++) begin
            p = a_in[t] * b_in[qpn_pkg::TERM_B[c][t]];
            prod1_in[c][t] = qpn_pkg::TERM_NEG[c][t] ? -p : p;
         end
      end
   end

   // ---------------------------------------------------------------------
   // Stage 2: exact product components, carrying 2F fraction bits.
   // ---------------------------------------------------------------------
   logic                 valid2_ff;
   logic                 zero2_ff;
   logic signed [PW-1:0] sum2_ff [4];
   logic signed [PW-1:0] sum2_in [4];
   logic                 zero2_in;

   always_comb begin
      zero2_in = 1'b1;
      for (int c = 0; c < 4; c++) begin
         sum2_in[c] = PW'(prod1_ff[c][0]) + PW'(prod1_ff[c][1])
                    + PW'(prod1_ff[c][2]) + PW'(prod1_ff[c][3]);
         if (sum2_in[c] != '0) begin
            zero2_in = 1'b0;
         end
      end
   end

   // ---------------------------------------------------------------------
   // Stage 3: choose the smallest right shift that brings every component
   // into the symmetric 32-bit range. Each candidate is checked on its own.
   // ---------------------------------------------------------------------
   logic                 valid3_ff;
   logic                 zero3_ff;
   logic signed [PW-1:0] sum3_ff [4];
   logic [SW-1:0]        shift3_ff;
   logic [SW-1:0]        shift3_in;
   logic [NS-1:0]        fits;

   always_comb begin
      logic signed [EW-1:0] ext;
      logic [EW-32:0]       upper;
      for (int s = 0; s < NS; s++) begin
         fits[s] = 1'b1;
         for (int c = 0; c < 4; c++) begin
            ext   = EW'(sum2_ff[c]) >>> s;
            upper = ext[EW-1:31];
            if (!((upper == '0) || ((&upper) && (ext[30:0] != '0)))) begin
               fits[s] = 1'b0;
            end
         end
      end
      shift3_in = SW'(NS - 1);
      for (int s = NS - 1; s >= 0; s--) begin
         if (fits[s]) begin
            shift3_in = SW'(s);
         end
      end
   end

   // ---------------------------------------------------------------------
   // Stage 4: apply the prescale (a floor shift) and split sign and magnitude.
   // ---------------------------------------------------------------------
   logic                 valid4_ff;
   logic                 zero4_ff;
   logic [MW-1:0]        mag4_ff [4];
   logic [3:0]           neg4_ff;
   logic [MW-1:0]        mag4_in [4];
   logic [3:0]           neg4_in;

   always_comb begin
      logic signed [PW-1:0] sh;
      logic signed [31:0]   v32;
      for (int c = 0; c < 4; c++) begin
         sh         = sum3_ff[c] >>> shift3_ff;
         v32        = 32'(sh);
         neg4_in[c] = v32[31];
         mag4_in[c] = MW'(v32[31] ? -v32 : v32);
      end
   end

   // ---------------------------------------------------------------------
   // Stage 5: squared magnitudes.
   // ---------------------------------------------------------------------
   logic                 valid5_ff;
   logic                 zero5_ff;
   logic [SQW-1:0]       sq5_ff [4];
   logic [3:0]           neg5_ff;
   logic [SQW-1:0]       sq5_in [4];

   always_comb begin
      for (int c = 0; c < 4; c++) begin
         sq5_in[c] = mag4_ff[c] * mag4_ff[c];
      end
   end

   // ---------------------------------------------------------------------
   // Stage 6: squared norm T and the starting remainder of the search,
   // R = 4*m^2*2^(2F) - (2q-1)^2*T with q = 0.
   // ---------------------------------------------------------------------
   qpn_pkg::stage_ctl_type ctl6_ff;
   logic [TW-1:0]          t6_ff;
   logic signed [RW-1:0]   r6_ff [4];
   logic [TW-1:0]          t6_in;
   logic signed [RW-1:0]   r6_in [4];

   always_comb begin
      t6_in = TW'(sq5_ff[0]) + TW'(sq5_ff[1]) + TW'(sq5_ff[2]) + TW'(sq5_ff[3]);
      for (int c = 0; c < 4; c++) begin
         r6_in[c] = ($signed(RW'(sq5_ff[c])) <<< (2 * FRAC + 2)) - $signed(RW'(t6_in));
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         valid1_ff <= 1'b0;
         valid2_ff <= 1'b0;
         valid3_ff <= 1'b0;
         valid4_ff <= 1'b0;
         valid5_ff <= 1'b0;
         ctl6_ff   <= '0;
      end else if (en) begin
         valid1_ff     <= req_chan.valid;
         valid2_ff     <= valid1_ff;
         valid3_ff     <= valid2_ff;
         valid4_ff     <= valid3_ff;
         valid5_ff     <= valid4_ff;
         ctl6_ff.valid <= valid5_ff;
         ctl6_ff.zero  <= zero5_ff;
         ctl6_ff.neg   <= neg5_ff;
      end
   end

   always_ff @(posedge clock) begin
      if (en) begin
         prod1_ff  <= prod1_in;
         sum2_ff   <= sum2_in;
         zero2_ff  <= zero2_in;
         sum3_ff   <= sum2_ff;
         zero3_ff  <= zero2_ff;
         shift3_ff <= shift3_in;
         mag4_ff   <= mag4_in;
         neg4_ff   <= neg4_in;
         zero4_ff  <= zero3_ff;
         sq5_ff    <= sq5_in;
         neg5_ff   <= neg4_ff;
         zero5_ff  <= zero4_ff;
         t6_ff     <= t6_in;
         r6_ff     <= r6_in;
      end
   end

   // ---------------------------------------------------------------------
   // Rounding search: one stage per result bit, most significant first.
   // Stage k decides bit FRAC - k of every component's magnitude.
   // ---------------------------------------------------------------------
   qpn_pkg::stage_ctl_type ctl_s [QW+1];
   logic signed [RW-1:0]   r_s   [QW+1][4];
   logic signed [RW-1:0]   y_s   [QW+1][4];
   logic [TW-1:0]          t_s   [QW+1];
   logic [QW-1:0]          q_s   [QW+1][4];

   assign ctl_s[0] = ctl6_ff;
   assign t_s[0]   = t6_ff;
   always_comb begin
      for (int c = 0; c < 4; c++) begin
         r_s[0][c] = r6_ff[c];
         y_s[0][c] = -$signed(RW'(t6_ff));
         q_s[0][c] = '0;
      end
   end

   for (genvar k = 0; k < QW; k++) begin : g_search
      qpn_root_stage #(
         .COMPONENT_WIDTH (COMPONENT_WIDTH),
         .BIT             (FRAC - k)
      ) u_stage (
         .clock   (clock),
         .reset   (reset),
         .en      (en),
         .ctl_in  (ctl_s[k]),
         .r_in    (r_s[k]),
         .y_in    (y_s[k]),
         .t_in    (t_s[k]),
         .q_in    (q_s[k]),
         .ctl_out (ctl_s[k+1]),
         .r_out   (r_s[k+1]),
         .y_out   (y_s[k+1]),
         .t_out   (t_s[k+1]),
         .q_out   (q_s[k+1])
      );
   end

   // ---------------------------------------------------------------------
   // Output register: restore signs, force zero for a degenerate product.
   // ---------------------------------------------------------------------
   logic                out_valid_ff;
   logic                degenerate_ff;
   logic signed [W-1:0] out_ff [4];
   logic signed [W-1:0] out_in [4];

   always_comb begin
      for (int c = 0; c < 4; c++) begin
         if (ctl_s[QW].zero) begin
            out_in[c] = '0;
         end else if (ctl_s[QW].neg[c]) begin
            out_in[c] = -$signed(W'(q_s[QW][c]));
         end else begin
            out_in[c] = $signed(W'(q_s[QW][c]));
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         out_valid_ff <= 1'b0;
      end else if (en) begin
         out_valid_ff <= ctl_s[QW].valid;
      end
   end

   always_ff @(posedge clock) begin
      if (en) begin
         out_ff        <= out_in;
         degenerate_ff <= ctl_s[QW].zero;
      end
   end

   assign rsp_chan.valid      = out_valid_ff;
   assign rsp_chan.out_w      = out_ff[0];
   assign rsp_chan.out_x      = out_ff[1];
   assign rsp_chan.out_y      = out_ff[2];
   assign rsp_chan.out_z      = out_ff[3];
   assign rsp_chan.degenerate = degenerate_ff;

endmodule

// File: hw/rtl/qpn_root_stage.sv
// One bit step of the pipelined rounding search for a normalized component.
`timescale 1ns / 1ps

module qpn_root_stage #(
   parameter int COMPONENT_WIDTH = 16,
   parameter int BIT = 0
) (
   input  logic                                              clock,
   input  logic                                              reset,
   input  logic                                              en,
   input  qpn_pkg::stage_ctl_type                            ctl_in,
   input  logic signed [2*COMPONENT_WIDTH+65:0]              r_in [4],
   input  logic signed [2*COMPONENT_WIDTH+65:0]              y_in [4],
   input  logic [qpn_pkg::TOT_WIDTH-1:0]                     t_in,
   input  logic [COMPONENT_WIDTH-2:0]                        q_in [4],
   output qpn_pkg::stage_ctl_type                            ctl_out,
   output logic signed [2*COMPONENT_WIDTH+65:0]              r_out [4],
   output logic signed [2*COMPONENT_WIDTH+65:0]              y_out [4],
   output logic [qpn_pkg::TOT_WIDTH-1:0]                     t_out,
   output logic [COMPONENT_WIDTH-2:0]                        q_out [4]
);

   localparam int FRAC = COMPONENT_WIDTH - 2;
   localparam int RW   = 2 * FRAC + 70;
   localparam int QW   = FRAC + 1;

   qpn_pkg::stage_ctl_type           ctl_ff;
   logic signed [RW-1:0]             r_ff [4];
   logic signed [RW-1:0]             y_ff [4];
   logic [qpn_pkg::TOT_WIDTH-1:0]    t_ff;
   logic [QW-1:0]                    q_ff [4];

   logic signed [RW-1:0]             r_in_next [4];
   logic signed [RW-1:0]             y_in_next [4];
   logic [QW-1:0]                    q_in_next [4];
   logic signed [RW-1:0]             t_wide;

   // Trying bit BIT raises (2q-1)^2*T by 2^(BIT+2)*Y + 2^(2*BIT+2)*T, Y = (2q-1)*T.
   always_comb begin
      logic signed [RW-1:0] d;
      t_wide = $signed(RW'(t_in));
      for (int c = 0; c < 4; c++) begin
         d = (y_in[c] <<< (BIT + 2)) + (t_wide <<< (2 * BIT + 2));
         if (d <= r_in[c]) begin
            r_in_next[c] = r_in[c] - d;
            y_in_next[c] = y_in[c] + (t_wide <<< (BIT + 1));
            q_in_next[c] = q_in[c] | (QW'(1) << BIT);
         end else begin
            r_in_next[c] = r_in[c];
            y_in_next[c] = y_in[c];
            q_in_next[c] = q_in[c];
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         ctl_ff <= '0;
      end else if (en) begin
         ctl_ff <= ctl_in;
      end
   end

   always_ff @(posedge clock) begin
      if (en) begin
         r_ff <= r_in_next;
         y_ff <= y_in_next;
         q_ff <= q_in_next;
         t_ff <= t_in;
      end
   end

   assign ctl_out = ctl_ff;
   assign r_out   = r_ff;
   assign y_out   = y_ff;
   assign t_out   = t_ff;
   assign q_out   = q_ff;

endmodule

// File: hw/rtl/qpn_checker.sv
// Port-level checks of the normalized quaternion product block and their binding.
`timescale 1ns / 1ps

module qpn_port_checker #(
   parameter int COMPONENT_WIDTH = 16
) (
   input logic                              clock,
   input logic                              reset,
   input logic                              rsp_valid,
   input logic                              rsp_ready,
   input logic signed [COMPONENT_WIDTH-1:0] out_w,
   input logic signed [COMPONENT_WIDTH-1:0] out_x,
   input logic signed [COMPONENT_WIDTH-1:0] out_y,
   input logic signed [COMPONENT_WIDTH-1:0] out_z,
   input logic                              degenerate
);

   localparam logic signed [COMPONENT_WIDTH-1:0] ONE =
      $signed(COMPONENT_WIDTH'(1) << (COMPONENT_WIDTH - 2));

   // A waiting response stays until the transfer.
   a_rsp_hold: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && !rsp_ready |=> rsp_valid)
      else $error("response dropped while stalled");

   // The pipeline is empty right after reset.
   a_reset_empty: assert property (@(posedge clock)
      reset |=> !rsp_valid)
      else $error("response valid after reset");

   a_degenerate_zero: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && degenerate |->
         out_w == '0 && out_x == '0 && out_y == '0 && out_z == '0)
      else $error("degenerate response with nonzero components");

   // A unit quaternion always has at least one component of half size or more.
   a_unit_nonzero: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && !degenerate |->
         out_w != '0 || out_x != '0 || out_y != '0 || out_z != '0)
      else $error("normalized response is all zero");

   a_unit_range: assert property (@(posedge clock) disable iff (reset)
      rsp_valid |->
         out_w <= ONE && out_w >= -ONE && out_x <= ONE && out_x >= -ONE &&
         out_y <= ONE && out_y >= -ONE && out_z <= ONE && out_z >= -ONE)
      else $error("normalized component beyond one");

endmodule

bind quaternion_product_normalized qpn_port_checker #(
   .COMPONENT_WIDTH (COMPONENT_WIDTH)
) u_qpn_checker (
   .clock      (clock),
   .reset      (reset),
   .rsp_valid  (rsp_chan.valid),
   .rsp_ready  (rsp_chan.ready),
   .out_w      (rsp_chan.out_w),
   .out_x      (rsp_chan.out_x),
   .out_y      (rsp_chan.out_y),
   .out_z      (rsp_chan.out_z),
   .degenerate (rsp_chan.degenerate)
);

// File: bench/qpn_checker.sv
// Watching checker for the normalized quaternion product block: predicts and compares results.
`timescale 1ns / 1ps

module qpn_checker #(
   parameter int COMPONENT_WIDTH = 16
) (
   input  logic clock,
   input  logic reset,
   qpn_req_if   req_chan,
   qpn_rsp_if   rsp_chan,
   output int   fail_count,
   output int   pending
);

   localparam int FRAC = COMPONENT_WIDTH - 2;
   localparam longint VMAX = 64'sd2147483647;

   typedef logic signed [COMPONENT_WIDTH-1:0] comp_t;

   typedef struct packed {
      comp_t w;
      comp_t x;
      comp_t y;
      comp_t z;
      logic  degenerate;
   } unit_quat_t;

   unit_quat_t expected_units[$];

   // Exact Hamilton product, then each component divided by the norm and rounded
   // to nearest with ties away from zero, by a bitwise search on squared values.
   function automatic unit_quat_t unit_product(input comp_t aw, ax, ay, az,
                                               input comp_t bw, bx, by, bz);
      longint     prod [4];
      longint     scaled [4];
      bit [127:0] mag [4];
      bit [127:0] total;
      bit [127:0] rhs;
      bit [127:0] cand;
      bit [127:0] odd;
      bit [127:0] root;
      bit         fits;
      comp_t      comp [4];
      unit_quat_t res;
      prod[0] = longint'(aw) * bw - longint'(ax) * bx - longint'(ay) * by - longint'(az) * bz;
      prod[1] = longint'(aw) * bx + longint'(ax) * bw + longint'(ay) * bz - longint'(az) * by;
      prod[2] = longint'(aw) * by - longint'(ax) * bz + longint'(ay) * bw + longint'(az) * bx;
      prod[3] = longint'(aw) * bz + longint'(ax) * by - longint'(ay) * bx + longint'(az) * bw;
      if (prod[0] == 0 && prod[1] == 0 && prod[2] == 0 && prod[3] == 0) begin
         res = '0;
         res.degenerate = 1'b1;
         return res;
      end
      // Shift right until every component fits in 31 magnitude bits.
      for (int s = 0; s < 64; s++) begin
         fits = 1'b1;
         for (int c = 0; c < 4; c++) begin
            scaled[c] = prod[c] >>> s;
            if (scaled[c] > VMAX || scaled[c] < -VMAX) fits = 1'b0;
         end
         if (fits) break;
      end
      total = '0;
      for (int c = 0; c < 4; c++) begin
         mag[c] = (scaled[c] < 0) ? 128'(-scaled[c]) : 128'(scaled[c]);
         total += mag[c] * mag[c];
      end
      for (int c = 0; c < 4; c++) begin
         rhs  = (mag[c] * mag[c]) << (2 * FRAC + 2);
         root = '0;
         for (int b = FRAC; b >= 0; b--) begin
            cand = root | (128'd1 << b);
            odd  = 2 * cand - 1;
            if (odd * odd * total <= rhs) root = cand;
         end
         comp[c] = (scaled[c] < 0) ? comp_t'(-root) : comp_t'(root);
      end
      res.w = comp[0];
      res.x = comp[1];
      res.y = comp[2];
      res.z = comp[3];
      res.degenerate = 1'b0;
      return res;
   endfunction

   assign pending = expected_units.size();

   initial fail_count = 0;

   always @(posedge clock) begin
      unit_quat_t want;
      if (!reset) begin
         if (rsp_chan.valid && rsp_chan.ready) begin
            if (expected_units.size() == 0) begin
               $error("response transfer with no request outstanding");
               fail_count <= fail_count + 1;
            end else begin
               want = expected_units.pop_front();
               if (rsp_chan.out_w !== want.w || rsp_chan.out_x !== want.x ||
                   rsp_chan.out_y !== want.y || rsp_chan.out_z !== want.z ||
                   rsp_chan.degenerate !== want.degenerate)
                  fail_count <= fail_count + 1;
               if (rsp_chan.out_w !== want.w)
                  $error("out_w expected %0d got %0d", want.w, rsp_chan.out_w);
               if (rsp_chan.out_x !== want.x)
                  $error("out_x expected %0d got %0d", want.x, rsp_chan.out_x);
               if (rsp_chan.out_y !== want.y)
                  $error("out_y expected %0d got %0d", want.y, rsp_chan.out_y);
               if (rsp_chan.out_z !== want.z)
                  $error("out_z expected %0d got %0d", want.z, rsp_chan.out_z);
               if (rsp_chan.degenerate !== want.degenerate)
                  $error("degenerate expected %0d got %0d", want.degenerate,
                         rsp_chan.degenerate);
            end
         end
         if (req_chan.valid && req_chan.ready)
            expected_units.push_back(unit_product(req_chan.a_w, req_chan.a_x,
                                                  req_chan.a_y, req_chan.a_z,
                                                  req_chan.b_w, req_chan.b_x,
                                                  req_chan.b_y, req_chan.b_z));
      end
   end

endmodule

// File: bench/tb.sv
// Top of the normalized quaternion product bench: clock, reset, stimulus and verdict.
`timescale 1ns / 1ps

module tb;

   localparam int CW = 16;
   // Far above the slowest correct run: about 1750 items with a mostly stalled receiver.
   localparam int CYCLE_LIMIT = 400000;

   logic clock;
   logic reset;
   int   fail_count;
   int   pending;
   int   cycle_count;
   int   send_idle_pct;
   int   recv_idle_pct;

   qpn_req_if #(.COMPONENT_WIDTH(CW)) req_chan ();
   qpn_rsp_if #(.COMPONENT_WIDTH(CW)) rsp_chan ();

   quaternion_product_normalized #(.COMPONENT_WIDTH(CW)) dut (
      .clock    (clock),
      .reset    (reset),
      .req_chan (req_chan),
      .rsp_chan (rsp_chan)
   );

   qpn_checker #(.COMPONENT_WIDTH(CW)) checker_unit (
      .clock      (clock),
      .reset      (reset),
      .req_chan   (req_chan),
      .rsp_chan   (rsp_chan),
      .fail_count (fail_count),
      .pending    (pending)
   );

   initial clock = 1'b0;
   always #1 clock = ~clock;

   // The receiver decides at each falling edge whether it takes a response at
   // the next rising edge, so stalls land on every stage of the pipeline.
   always @(negedge clock) begin
      rsp_chan.ready <= ($urandom_range(99) >= recv_idle_pct);
   end

   // Hard stop in case the block hangs.
   always @(posedge clock) begin
      cycle_count <= cycle_count + 1;
      if (cycle_count > CYCLE_LIMIT) begin
         $display("tb failed");
         $finish;
      end
   end

   // Offers one item and holds it until the block takes it. Idle cycles before
   // the item drop valid; the item is driven on a falling edge and the transfer
   // is seen at a rising edge where ready is high.
   task automatic send_quats(input int aw, ax, ay, az, bw, bx, by, bz);
      while ($urandom_range(99) < send_idle_pct) begin
         @(negedge clock);
         req_chan.valid <= 1'b0;
      end
      @(negedge clock);
      req_chan.valid <= 1'b1;
      req_chan.a_w   <= aw[CW-1:0];
      req_chan.a_x   <= ax[CW-1:0];
      req_chan.a_y   <= ay[CW-1:0];
      req_chan.a_z   <= az[CW-1:0];
      req_chan.b_w   <= bw[CW-1:0];
      req_chan.b_x   <= bx[CW-1:0];
      req_chan.b_y   <= by[CW-1:0];
      req_chan.b_z   <= bz[CW-1:0];
      do @(posedge clock); while (!req_chan.ready);
   endtask

   function automatic int full_comp();
      return int'($urandom_range(65535)) - 32768;
   endfunction

   function automatic int tiny_comp();
      return int'($urandom_range(16)) - 8;
   endfunction

   // Near-unit components, as an attitude stream would carry.
   function automatic int unit_comp();
      return int'($urandom_range(32768)) - 16384;
   endfunction

   // One random item: full-range values half the time, else tiny operands that
   // stress the rounding, zero operands for the degenerate path, or near-unit pairs.
   task automatic send_random();
      int pick;
      pick = $urandom_range(99);
      if (pick < 50)
         send_quats(full_comp(), full_comp(), full_comp(), full_comp(),
                    full_comp(), full_comp(), full_comp(), full_comp());
      else if (pick < 70)
         send_quats(tiny_comp(), tiny_comp(), tiny_comp(), tiny_comp(),
                    tiny_comp(), tiny_comp(), tiny_comp(), tiny_comp());
      else if (pick < 78)
         send_quats(0, 0, 0, 0, full_comp(), full_comp(), full_comp(), full_comp());
      else if (pick < 85)
         send_quats(full_comp(), full_comp(), full_comp(), full_comp(), 0, 0, 0, 0);
      else
         send_quats(unit_comp(), unit_comp(), unit_comp(), unit_comp(),
                    unit_comp(), unit_comp(), unit_comp(), unit_comp());
   endtask

   initial begin
      cycle_count    = 0;
      send_idle_pct  = 27;
      recv_idle_pct  = 63;
      reset          = 1'b1;
      req_chan.valid = 1'b0;
      req_chan.a_w   = '0;
      req_chan.a_x   = '0;
      req_chan.a_y   = '0;
      req_chan.a_z   = '0;
      req_chan.b_w   = '0;
      req_chan.b_x   = '0;
      req_chan.b_y   = '0;
      req_chan.b_z   = '0;
      rsp_chan.ready = 1'b0;
      repeat (6) @(posedge clock);
      @(negedge clock);
      reset = 1'b0;

      // Directed part. A zero product is the only degenerate case, and since
      // quaternions have no zero divisors it needs a zero operand.
      send_quats(0, 0, 0, 0, 0, 0, 0, 0);
      send_quats(0, 0, 0, 0, 32767, -32768, 32767, -32768);
      send_quats(-32768, 32767, -32768, 32767, 0, 0, 0, 0);
      send_quats(16384, 0, 0, 0, 16384, 0, 0, 0);
      send_quats(0, 16384, 0, 0, 0, 16384, 0, 0);
      send_quats(0, 0, 16384, 0, 0, 0, 0, 16384);
      // Full-scale operands: the largest products need the prescale shift.
      send_quats(32767, 32767, 32767, 32767, 32767, 32767, 32767, 32767);
      send_quats(-32768, -32768, -32768, -32768, -32768, -32768, -32768, -32768);
      send_quats(-32768, 32767, -32768, 32767, 32767, -32768, 32767, -32768);
      send_quats(32767, -32768, -32768, -32768, -32768, 32767, 32767, 32767);
      // Smallest nonzero products and other nonzero cases.
      send_quats(1, 0, 0, 0, 1, 0, 0, 0);
      send_quats(0, 0, 0, -1, 0, 1, 0, 0);
      send_quats(1, 1, 1, 1, 1, -1, -1, -1);
      send_quats(1, 1, 0, 0, 1, 0, 0, 0);
      send_quats(3, -1, 2, 0, -2, 1, 1, 5);
      send_quats(-1, -1, -1, -1, -1, -1, -1, -1);
      send_quats(11585, 11585, 0, 0, 11585, 0, 11585, 0);
      send_quats(-32768, 0, 0, 0, 1, 0, 0, 0);
      @(negedge clock);
      req_chan.valid <= 1'b0;

      // Hold off until the pipeline has drained completely.
      while (pending != 0) @(posedge clock);

      repeat (583) send_random();
      send_idle_pct = 63;
      recv_idle_pct = 27;
      repeat (583) send_random();
      send_idle_pct = 0;
      recv_idle_pct = 0;
      repeat (584) send_random();
      @(negedge clock);
      req_chan.valid <= 1'b0;

      while (pending != 0) @(posedge clock);
      repeat (40) @(posedge clock);
      if (fail_count == 0) begin
         $display("tb passed");
      end else begin
         $display("tb failed");
      end
      $finish;
   end

endmodule
